// ===== rtl/gcc_pkg.sv =====
`default_nettype none

package gcc_pkg;

  localparam int unsigned MAX_CODE_LENGTH = 63;

  localparam int unsigned LEN_W = 6;
  localparam int unsigned GEN_W = 64;
  localparam int unsigned REM_W = 63;
  localparam int unsigned VERDICT_W = 2;

  localparam logic [VERDICT_W-1:0] VERDICT_REJECT      = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_VALID       = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_NOT_DIVISOR = 2'd2;

  typedef struct packed {
    logic [LEN_W-1:0] code_length;
    logic [LEN_W-1:0] info_length;
    logic [GEN_W-1:0] generator_bits;
  } item_t;

  typedef struct packed {
    logic [VERDICT_W-1:0] verdict;
    logic [REM_W-1:0]     remainder_bits;
    logic [LEN_W-1:0]     poly_degree;
  } result_t;

  // control broadcast along the cell row
  typedef struct packed {
    logic clear;
    logic step;
    logic dbit;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/gcc_cell.sv =====
`default_nettype none

module gcc_cell (
  input  wire logic clk,
  input  wire logic clear,
  input  wire logic step,
  input  wire logic shift_in,
  input  wire logic fb,
  input  wire logic tap,
  output logic      q
);

  // one remainder coefficient: shift up from the lower neighbour, add feedback where g has a term
  always_ff @(posedge clk) begin
    if (clear) begin
      q <= 1'b0;
    end else if (step) begin
      q <= shift_in ^ (fb & tap);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gcc_divider.sv =====
`default_nettype none

module gcc_divider (
  input  wire logic                                clk,
  input  wire gcc_pkg::cell_ctrl_t                 ctrl,
  input  wire logic [gcc_pkg::REM_W-1:0]           taps,
  input  wire logic [gcc_pkg::LEN_W-1:0]           degree,
  output logic      [gcc_pkg::REM_W-1:0]           rem
);

  logic                        fb;
  logic [gcc_pkg::LEN_W-1:0]   fb_idx;
  logic [gcc_pkg::REM_W-1:0]   shift_in;

  // the bit about to reach x^degree decides whether g is subtracted
  assign fb_idx = gcc_pkg::LEN_W'(degree - 1'b1);
  assign fb     = (degree == '0) ? ctrl.dbit : rem[fb_idx];

  assign shift_in = {rem[gcc_pkg::REM_W-2:0], ctrl.dbit};

  for (genvar i = 0; i < gcc_pkg::REM_W; i++) begin : g_cell
    gcc_cell u_cell (
      .clk      (clk),
      .clear    (ctrl.clear),
      .step     (ctrl.step),
      .shift_in (shift_in[i]),
      .fb       (fb),
      .tap      (taps[i]),
      .q        (rem[i])
    );
  end

endmodule

`default_nettype wire

// ===== rtl/cyclic_generator_check_unit.sv =====
`default_nettype none

// channel  | direction | payload           | transfer when
// item     | in        | gcc_pkg::item_t   | item_valid && !item_stall
// result   | out       | gcc_pkg::result_t | result_valid && !result_stall
//
// an item passes from transfer to result through the degree search (byte in SCAN_HI, then
// bit in SCAN_LO), the bit-serial division of the dividend through the cell row, and the
// write of the result register in FINISH; rejected candidates and the zero polynomial
// skip the division. the unit then returns to IDLE, where the next item is taken.
// rst is synchronous; a held result stalls only the final write, and a new item is taken
// only after the previous one has reached the result register.

module cyclic_generator_check_unit (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_stall,
  input  wire gcc_pkg::item_t   item,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output gcc_pkg::result_t      result
);

  typedef enum logic [2:0] {
    IDLE,
    SCAN_HI,
    SCAN_LO,
    DIVIDE,
    FINISH
  } state_t;

  state_t state;

  logic [gcc_pkg::LEN_W-1:0] code_length;
  logic [gcc_pkg::LEN_W-1:0] info_length;
  logic [gcc_pkg::GEN_W-1:0] gen;
  logic [2:0]                hi_byte;
  logic [gcc_pkg::LEN_W-1:0] degree;
  logic                      reject;
  logic                      gen_zero;
  logic [gcc_pkg::LEN_W-1:0] step_cnt;

  logic [7:0]                byte_any;
  logic [7:0]                sel_byte;
  logic [gcc_pkg::LEN_W-1:0] degree_next;
  logic                      reject_next;
  logic                      out_free;
  gcc_pkg::cell_ctrl_t       cell_ctrl;
  logic [gcc_pkg::REM_W-1:0] rem;

  function automatic logic [2:0] top_of8(input logic [7:0] v);
    logic [2:0] idx;
    idx = '0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) begin
        idx = 3'(i);
      end
    end
    return idx;
  endfunction

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      byte_any[b] = |gen[8*b +: 8];
    end
  end

  assign sel_byte    = gen[{hi_byte, 3'b000} +: 8];
  assign degree_next = {hi_byte, top_of8(sel_byte)};

  assign reject_next = ({1'b0, code_length} > 7'(gcc_pkg::MAX_CODE_LENGTH))
                    || (info_length > code_length)
                    || (degree_next != gcc_pkg::LEN_W'(code_length - info_length));

  assign out_free   = !result_valid || !result_stall;
  assign item_stall = (state != IDLE);

  // dividend x^l + 1 fed highest coefficient first
  always_comb begin
    cell_ctrl.clear = (state == SCAN_LO);
    cell_ctrl.step  = (state == DIVIDE);
    cell_ctrl.dbit  = (step_cnt == '0) ^ (step_cnt == code_length);
  end

  gcc_divider u_divider (
    .clk    (clk),
    .ctrl   (cell_ctrl),
    .taps   (gen[gcc_pkg::REM_W-1:0]),
    .degree (degree),
    .rem    (rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      result_valid <= 1'b0;
    end else begin
      // in FINISH the valid flag is either reloaded or held
      if (result_valid && !result_stall && state != FINISH) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (item_valid) begin
            code_length <= item.code_length;
            info_length <= item.info_length;
            gen         <= item.generator_bits;
            state       <= SCAN_HI;
          end
        end
        SCAN_HI: begin
          hi_byte <= top_of8(byte_any);
          state   <= SCAN_LO;
        end
        SCAN_LO: begin
          degree   <= degree_next;
          reject   <= reject_next;
          gen_zero <= ~|byte_any;
          step_cnt <= '0;
          if (reject_next || ~|byte_any) begin
            state <= FINISH;
          end else begin
            state <= DIVIDE;
          end
        end
        DIVIDE: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == code_length) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (out_free) begin
            result.poly_degree <= degree;
            if (reject) begin
              result.verdict        <= gcc_pkg::VERDICT_REJECT;
              result.remainder_bits <= '0;
            end else if (gen_zero) begin
              result.verdict        <= gcc_pkg::VERDICT_NOT_DIVISOR;
              result.remainder_bits <= '0;
            end else begin
              result.verdict        <= (rem == '0) ? gcc_pkg::VERDICT_VALID
                                                   : gcc_pkg::VERDICT_NOT_DIVISOR;
              result.remainder_bits <= rem;
            end
            result_valid <= 1'b1;
            state        <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
